[sv/gcl_pkg.sv]
// Package: widths, map codes, colour-stop ROM and stop rescaling for the colormap
`default_nettype none
package gcl_pkg;

  localparam int SAMPLE_W          = 18;
  localparam int MAG_W             = SAMPLE_W - 1;
  localparam int CH_OUT_W          = 8;
  localparam int SEL_W             = 2;
  localparam int NUM_MAPS          = 4;
  localparam int MAX_STOPS         = 11;
  localparam int IDX_W             = 4;
  localparam int NUM_CH            = 3;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CHANNEL_BITS_DEF  = 8;

  localparam logic [SEL_W-1:0] MAP_GRAY    = 2'd0;
  localparam logic [SEL_W-1:0] MAP_RAINBOW = 2'd1;
  localparam logic [SEL_W-1:0] MAP_THERMAL = 2'd2;
  localparam logic [SEL_W-1:0] MAP_OPPOSED = 2'd3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [IDX_W-1:0] stop_idx_t;

  localparam stop_idx_t STOP_LAST [NUM_MAPS] = '{4'd1, 4'd10, 4'd5, 4'd6};

  localparam logic [7:0] STOP_ROM [NUM_MAPS][MAX_STOPS][NUM_CH] = '{
    '{ '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00},
       '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00},
       '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00},
       '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00} },
    '{ '{8'h80, 8'h00, 8'h80}, '{8'h60, 8'h00, 8'hC0}, '{8'h00, 8'h00, 8'hFF},
       '{8'h00, 8'h80, 8'hFF}, '{8'h00, 8'hFF, 8'hFF}, '{8'h00, 8'hFF, 8'h00},
       '{8'h80, 8'hFF, 8'h00}, '{8'hFF, 8'hFF, 8'h00}, '{8'hFF, 8'hFF, 8'hFF},
       '{8'hFF, 8'h80, 8'h00}, '{8'hFF, 8'h00, 8'h00} },
    '{ '{8'h00, 8'h00, 8'hA0}, '{8'h60, 8'h00, 8'hA0}, '{8'hA0, 8'h00, 8'h60},
       '{8'hE0, 8'h20, 8'h20}, '{8'hFF, 8'hF0, 8'h00}, '{8'hFF, 8'hFF, 8'hFF},
       '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00},
       '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00} },
    '{ '{8'h00, 8'h00, 8'hFF}, '{8'h10, 8'hC0, 8'hF0}, '{8'h20, 8'hF0, 8'h00},
       '{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'hF0, 8'h20}, '{8'hFF, 8'h80, 8'h10},
       '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00},
       '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00} }
  };

  // rescale an 8-bit stop to the channel full scale, rounded
  function automatic int stop_scale(input int v, input int cb);
    int full;
    full = (1 << cb) - 1;
    return (v * full * 2 + 255) / 510;
  endfunction

endpackage
`default_nettype wire

[sv/gcl_front.sv]
// Front end: accept samples, clamp, scale by segment count and classify
`default_nettype none
module gcl_front
  import gcl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ENTRY_W   = 1 + IDX_W + FRAC_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [SEL_W-1:0]           map_sel,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output      logic                       q_wr_valid,
  input  wire logic                       q_wr_ready,
  output      logic [ENTRY_W-1:0]         q_wr_data
);

  localparam int RAW_W  = MAG_W + IDX_W;
  localparam int PROD_W = (RAW_W > FRAC_BITS + 1) ? RAW_W : FRAC_BITS + 1;

  logic              fr_v_r, fr_v_nxt;
  logic [RAW_W-1:0]  fr_scaled_r, fr_scaled_nxt;
  logic              take;
  stop_idx_t         last;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] scaled_ext;
  logic [PROD_W-1:0] seg_full;
  logic              at_end;
  stop_idx_t         idx;
  logic [FRAC_BITS-1:0] t;

  assign in_ready = !fr_v_r || q_wr_ready;
  assign take     = in_valid && in_ready;
  assign last     = STOP_LAST[map_sel];
  assign mag      = in_sample[SAMPLE_W-1] ? '0 : in_sample[MAG_W-1:0];

  always_comb begin
    fr_scaled_nxt = fr_scaled_r;
    fr_v_nxt      = fr_v_r;
    if (take) begin
      fr_scaled_nxt = RAW_W'(mag) * RAW_W'(last);
      fr_v_nxt      = 1'b1;
    end else if (q_wr_ready) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
    fr_scaled_r <= fr_scaled_nxt;
  end

  assign scaled_ext = PROD_W'(fr_scaled_r);
  assign seg_full   = scaled_ext >> FRAC_BITS;
  assign at_end     = seg_full >= PROD_W'(last);
  assign idx        = at_end ? last : seg_full[IDX_W-1:0];
  assign t          = scaled_ext[FRAC_BITS-1:0];

  assign q_wr_valid = fr_v_r;
  assign q_wr_data  = {at_end, idx, t};

endmodule
`default_nettype wire

[sv/gcl_queue.sv]
// Two-entry queue between the front end and the interpolation back end
`default_nettype none
module gcl_queue #(
  parameter int ENTRY_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output      logic               wr_ready,
  input  wire logic [ENTRY_W-1:0] wr_data,
  output      logic               rd_valid,
  input  wire logic               rd_ready,
  output      logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[sv/gcl_back.sv]
// Back end: stop lookup, per-channel interpolation and output register
`default_nettype none
module gcl_back
  import gcl_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int ENTRY_W      = 1 + IDX_W + FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [SEL_W-1:0]    map_sel,
  input  wire logic                q_rd_valid,
  output      logic                q_rd_ready,
  input  wire logic [ENTRY_W-1:0]  q_rd_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [CH_OUT_W-1:0] out_red,
  output      logic [CH_OUT_W-1:0] out_green,
  output      logic [CH_OUT_W-1:0] out_blue
);

  localparam int CB  = CHANNEL_BITS;
  localparam int MUL_W = CB + FRAC_BITS + 2;

  logic [CB-1:0] stop_tab [NUM_MAPS][MAX_STOPS][NUM_CH];

  for (genvar m = 0; m < NUM_MAPS; m++) begin : g_map
    for (genvar s = 0; s < MAX_STOPS; s++) begin : g_stop
      for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        assign stop_tab[m][s][c] = CB'(stop_scale(int'(STOP_ROM[m][s][c]), CB));
      end
    end
  end

  logic                 at_end;
  stop_idx_t            idx, idx_nx;
  logic [FRAC_BITS-1:0] t;

  assign {at_end, idx, t} = q_rd_data;
  assign idx_nx = at_end ? idx : idx + stop_idx_t'(1);

  logic              s1_v_r, out_v_r;
  logic              out_load, s1_load;
  logic [CB-1:0]     s1_c1_r [NUM_CH];
  logic [MUL_W-1:0]  s1_prod_r [NUM_CH];
  logic [CB-1:0]     out_c_r [NUM_CH];
  logic [CB-1:0]     c1 [NUM_CH];
  logic [CB-1:0]     c2 [NUM_CH];
  logic signed [CB:0]        delta [NUM_CH];
  logic signed [MUL_W-1:0]   prod [NUM_CH];
  logic [MUL_W-1:0]          sum [NUM_CH];

  assign out_load   = !out_v_r || out_ready;
  assign s1_load    = !s1_v_r || out_load;
  assign q_rd_ready = s1_load;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_math
    assign c1[c]    = stop_tab[map_sel][idx][c];
    assign c2[c]    = stop_tab[map_sel][idx_nx][c];
    assign delta[c] = $signed({1'b0, c2[c]}) - $signed({1'b0, c1[c]});
    assign prod[c]  = MUL_W'(delta[c]) * $signed({1'b0, t});
    assign sum[c]   = (MUL_W'(s1_c1_r[c]) << FRAC_BITS) + s1_prod_r[c]
                      + (MUL_W'(1) << (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= q_rd_valid;
      end
      if (out_load) begin
        out_v_r <= s1_v_r;
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (s1_load) begin
        s1_c1_r[c]   <= c1[c];
        s1_prod_r[c] <= prod[c];
      end
      if (out_load) begin
        out_c_r[c] <= sum[c][FRAC_BITS +: CB];
      end
    end
  end

  assign out_valid = out_v_r;

  if (CB >= CH_OUT_W) begin : g_trunc
    assign out_red   = out_c_r[CH_RED][CH_OUT_W-1:0];
    assign out_green = out_c_r[CH_GREEN][CH_OUT_W-1:0];
    assign out_blue  = out_c_r[CH_BLUE][CH_OUT_W-1:0];
  end else begin : g_ext
    assign out_red   = CH_OUT_W'(out_c_r[CH_RED]);
    assign out_green = CH_OUT_W'(out_c_r[CH_GREEN]);
    assign out_blue  = CH_OUT_W'(out_c_r[CH_BLUE]);
  end

endmodule
`default_nettype wire

[sv/gradient_colormap_lerp_top.sv]
// Top level of the piecewise-linear gradient colormap
//
// Maps a signed fixed-point intensity sample to an RGB colour using one of
// four ROM gradients (grayscale, rainbow, thermal, opposed) chosen by
// cfg_wr_data. Sustains one item per clock while out_ready is high; an
// accepted item passes the input register, the two-entry queue, the lookup
// and multiply stage and the rounding and output register in turn. Write
// the map select only while no item is in flight.
`default_nettype none
module gradient_colormap_lerp_top
  import gcl_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [SEL_W-1:0]           cfg_wr_data,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [CH_OUT_W-1:0]        out_red,
  output      logic [CH_OUT_W-1:0]        out_green,
  output      logic [CH_OUT_W-1:0]        out_blue
);

  localparam int ENTRY_W = 1 + IDX_W + FRAC_BITS;

  logic [SEL_W-1:0]   map_sel_r;
  logic               q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  logic [ENTRY_W-1:0] q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_sel_r <= MAP_GRAY;
    end else if (cfg_wr_en) begin
      map_sel_r <= cfg_wr_data;
    end
  end

  gcl_front #(
    .FRAC_BITS (FRAC_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .map_sel    (map_sel_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  gcl_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  gcl_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .map_sel    (map_sel_r),
    .q_rd_valid (q_rd_valid),
    .q_rd_ready (q_rd_ready),
    .q_rd_data  (q_rd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

endmodule
`default_nettype wire
